// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the follower checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");

// property checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("%m: assertion failed");

`endif

// ----- hw/rtl/dsf3_pkg.sv -----
// ----------------------------------------------------------------------------
// dsf3_pkg
// Shared constants, codes and controller/datapath interface types for the
// 3D spring follower.
// ----------------------------------------------------------------------------
package dsf3_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DT_BITS   = 16;
  localparam int DIV_STEPS = 64;
  localparam int SQRT_STEPS = 32;

  localparam logic [30:0] RESET_DAMPING_K    = 31'd2293760;
  localparam logic [30:0] RESET_DAMPING_RATE = 31'd65536;
  localparam logic [30:0] RESET_MAX_SPEED    = 31'd655360;

  localparam logic [1:0] REG_DAMPING_K    = 2'd0;
  localparam logic [1:0] REG_DAMPING_RATE = 2'd1;
  localparam logic [1:0] REG_MAX_SPEED    = 2'd2;

  localparam logic [1:0] AXIS_LAST = 2'd2;

  typedef enum logic [4:0] {
    OP_IDLE, OP_CAPTURE, OP_SNAP, OP_T_DIV, OP_T_SAVE, OP_SK_MUL, OP_SK_SAVE,
    OP_V1, OP_V2, OP_V3, OP_V4, OP_V5, OP_L_MUL, OP_L_ACC, OP_LIM_MUL,
    OP_LIM_CMP, OP_SQRT, OP_LEN_SAVE, OP_C_MUL, OP_C_DIV, OP_C_WR,
    OP_P_MUL, OP_P_ADD, OP_OUT
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SNAP, ST_T_DIV, ST_T_WAIT, ST_T_SAVE, ST_SK_MUL, ST_SK_SAVE,
    ST_V1, ST_V2, ST_V3, ST_V4, ST_V5, ST_L_MUL, ST_L_ACC, ST_LIM_MUL,
    ST_LIM_CMP, ST_SQRT, ST_SQRT_WAIT, ST_LEN_SAVE, ST_C_MUL, ST_C_DIV,
    ST_C_WAIT, ST_C_WR, ST_P_MUL, ST_P_ADD, ST_OUT
  } state_t;

  typedef struct packed {
    op_t        op;
    logic       foll;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic over;
    logic out_busy;
  } status_t;

endpackage

// ----- hw/rtl/dsf3_div.sv -----
// ----------------------------------------------------------------------------
// dsf3_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit
// per cycle. A zero divisor yields an all-ones quotient.
// ----------------------------------------------------------------------------
module dsf3_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [63:0] quo
);

  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem, quo[63]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(dsf3_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dvs <= den;
    end else if (busy) begin
      if (shifted >= {1'b0, dvs}) begin
        rem <= diff[31:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= shifted[31:0];
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

endmodule

// ----- hw/rtl/dsf3_sqrt.sv -----
// ----------------------------------------------------------------------------
// dsf3_sqrt
// Digit-by-digit integer square root of a 64-bit value, one root bit per
// cycle, floor result.
// ----------------------------------------------------------------------------
module dsf3_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x,
  output logic        done,
  output logic [31:0] root
);

  logic        busy;
  logic [4:0]  cnt;
  logic [33:0] rem;
  logic [63:0] xs;
  logic [34:0] r2;
  logic [34:0] trial;

  assign r2    = {rem[32:0], xs[63:62]};
  assign trial = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(dsf3_pkg::SQRT_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      root <= '0;
      xs   <= x;
    end else if (busy) begin
      xs <= {xs[61:0], 2'b00};
      if (r2 >= trial) begin
        rem  <= 34'(r2 - trial);
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= r2[33:0];
        root <= {root[30:0], 1'b0};
      end
    end
  end

endmodule

// ----- hw/rtl/dsf3_datapath.sv -----
// ----------------------------------------------------------------------------
// dsf3_datapath
// Follower state, configuration registers, shared multiplier, divider and
// square root unit, and the output word register.
// ----------------------------------------------------------------------------
module dsf3_datapath (
  input  logic                clk,
  input  logic                rst,
  input  dsf3_pkg::cmd_t      cmd,
  output dsf3_pkg::status_t   status,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [30:0]         cfg_data,
  input  logic signed [31:0]  goal_look_x,
  input  logic signed [31:0]  goal_look_y,
  input  logic signed [31:0]  goal_look_z,
  input  logic signed [31:0]  goal_eye_x,
  input  logic signed [31:0]  goal_eye_y,
  input  logic signed [31:0]  goal_eye_z,
  input  logic [15:0]         frame_dt,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  look_x,
  output logic signed [31:0]  look_y,
  output logic signed [31:0]  look_z,
  output logic signed [31:0]  eye_x,
  output logic signed [31:0]  eye_y,
  output logic signed [31:0]  eye_z,
  output logic                look_clamped,
  output logic                eye_clamped
);

  localparam int F = dsf3_pkg::FRAC_BITS;
  localparam int D = dsf3_pkg::DT_BITS;

  logic [30:0] damping_k, damping_rate, max_speed;
  logic [31:0] pt   [2][3];
  logic [31:0] vel  [2][3];
  logic [31:0] goal [2][3];
  logic [15:0] dt;
  logic [1:0]  clamped;
  logic [31:0] t, sk, p1, acc, len;
  logic [63:0] lsq;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  logic [31:0] pt_sel, vel_sel, goal_sel, diff, abs_sel;
  logic [31:0] qfield, dtfield;
  logic        div_start, sqrt_start;
  logic [63:0] div_num, div_quo;
  logic [31:0] div_den, root;
  logic        div_done, sqrt_done, out_load;

  assign pt_sel   = pt[cmd.foll][cmd.axis];
  assign vel_sel  = vel[cmd.foll][cmd.axis];
  assign goal_sel = goal[cmd.foll][cmd.axis];
  assign diff     = goal_sel - pt_sel;
  assign abs_sel  = vel_sel[31] ? 32'(0) - vel_sel : vel_sel;
  assign qfield   = prod[F+31:F];
  assign dtfield  = prod[D+31:D];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      dsf3_pkg::OP_SK_MUL: begin
        mul_a = {1'b0, t};
        mul_b = {1'b0, t};
      end
      dsf3_pkg::OP_V1: begin
        mul_a = {sk[31], sk};
        mul_b = {diff[31], diff};
      end
      dsf3_pkg::OP_V2: begin
        mul_a = {2'b00, damping_k};
        mul_b = {vel_sel[31], vel_sel};
      end
      dsf3_pkg::OP_V4: begin
        mul_a = {acc[31], acc};
        mul_b = {17'd0, dt};
      end
      dsf3_pkg::OP_L_MUL: begin
        mul_a = {1'b0, abs_sel};
        mul_b = {1'b0, abs_sel};
      end
      dsf3_pkg::OP_LIM_MUL: begin
        mul_a = {2'b00, max_speed};
        mul_b = {2'b00, max_speed};
      end
      dsf3_pkg::OP_C_MUL: begin
        mul_a = {1'b0, abs_sel};
        mul_b = {2'b00, max_speed};
      end
      dsf3_pkg::OP_P_MUL: begin
        mul_a = {vel_sel[31], vel_sel};
        mul_b = {17'd0, dt};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign div_start  = (cmd.op == dsf3_pkg::OP_T_DIV) || (cmd.op == dsf3_pkg::OP_C_DIV);
  assign div_num    = (cmd.op == dsf3_pkg::OP_T_DIV) ?
                      (64'(damping_k) << F) : prod[63:0];
  assign div_den    = (cmd.op == dsf3_pkg::OP_T_DIV) ? {damping_rate, 1'b0} : len;
  assign sqrt_start = (cmd.op == dsf3_pkg::OP_SQRT);

  dsf3_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  dsf3_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .x     (lsq),
    .done  (sqrt_done),
    .root  (root)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      damping_k    <= dsf3_pkg::RESET_DAMPING_K;
      damping_rate <= dsf3_pkg::RESET_DAMPING_RATE;
      max_speed    <= dsf3_pkg::RESET_MAX_SPEED;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dsf3_pkg::REG_DAMPING_K:    damping_k    <= cfg_data;
        dsf3_pkg::REG_DAMPING_RATE: damping_rate <= cfg_data;
        dsf3_pkg::REG_MAX_SPEED:    max_speed    <= cfg_data;
        default: ;
      endcase
    end
  end

  // follower state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int f = 0; f < 2; f++) begin
        for (int a = 0; a < 3; a++) begin
          pt[f][a]  <= '0;
          vel[f][a] <= '0;
        end
      end
    end else begin
      unique case (cmd.op)
        dsf3_pkg::OP_SNAP: begin
          for (int f = 0; f < 2; f++) begin
            for (int a = 0; a < 3; a++) begin
              pt[f][a]  <= goal[f][a];
              vel[f][a] <= '0;
            end
          end
        end
        dsf3_pkg::OP_V5:    vel[cmd.foll][cmd.axis] <= vel_sel + dtfield;
        dsf3_pkg::OP_C_WR:  vel[cmd.foll][cmd.axis] <=
                              vel_sel[31] ? 32'(0) - div_quo[31:0] : div_quo[31:0];
        dsf3_pkg::OP_P_ADD: pt[cmd.foll][cmd.axis] <= pt_sel + dtfield;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      dsf3_pkg::OP_CAPTURE: begin
        goal[0][0] <= goal_look_x;
        goal[0][1] <= goal_look_y;
        goal[0][2] <= goal_look_z;
        goal[1][0] <= goal_eye_x;
        goal[1][1] <= goal_eye_y;
        goal[1][2] <= goal_eye_z;
        dt         <= frame_dt;
        clamped    <= '0;
      end
      dsf3_pkg::OP_T_SAVE:   t   <= div_quo[31:0];
      dsf3_pkg::OP_SK_SAVE:  sk  <= prod[F+31:F];
      dsf3_pkg::OP_V2:       p1  <= qfield;
      dsf3_pkg::OP_V3:       acc <= p1 - qfield;
      dsf3_pkg::OP_L_ACC:    lsq <= ((cmd.axis == 2'd0) ? 64'd0 : lsq) + prod[63:0];
      dsf3_pkg::OP_LIM_CMP:  clamped[cmd.foll] <= status.over;
      dsf3_pkg::OP_LEN_SAVE: len <= root;
      default: ;
    endcase
  end

  // output word register
  assign out_load = (cmd.op == dsf3_pkg::OP_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      look_x       <= pt[0][0];
      look_y       <= pt[0][1];
      look_z       <= pt[0][2];
      eye_x        <= pt[1][0];
      eye_y        <= pt[1][1];
      eye_z        <= pt[1][2];
      look_clamped <= clamped[0];
      eye_clamped  <= clamped[1];
    end
  end

  assign status.div_done  = div_done;
  assign status.sqrt_done = sqrt_done;
  assign status.over      = lsq > prod[63:0];
  assign status.out_busy  = out_valid & ~out_ready;

endmodule

// ----- hw/rtl/dsf3_ctrl.sv -----
// ----------------------------------------------------------------------------
// dsf3_ctrl
// Sequencer for one step: spring gain, per-axis velocity update, speed
// limit with rescale, point update and output hand-off (or a snap).
// ----------------------------------------------------------------------------
module dsf3_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  dsf3_pkg::status_t  status,
  output dsf3_pkg::cmd_t     cmd
);

  dsf3_pkg::state_t state, state_next;
  logic       foll, foll_next;
  logic [1:0] axis, axis_next;
  logic       last_axis;

  assign last_axis = (axis == dsf3_pkg::AXIS_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dsf3_pkg::ST_IDLE;
      foll  <= 1'b0;
      axis  <= '0;
    end else begin
      state <= state_next;
      foll  <= foll_next;
      axis  <= axis_next;
    end
  end

  always_comb begin
    state_next = state;
    foll_next  = foll;
    axis_next  = axis;
    in_ready   = 1'b0;
    cmd.op     = dsf3_pkg::OP_IDLE;
    cmd.foll   = foll;
    cmd.axis   = axis;
    unique case (state)
      dsf3_pkg::ST_IDLE: begin
        in_ready = ~rst;
        if (in_valid && !rst) begin
          cmd.op     = dsf3_pkg::OP_CAPTURE;
          foll_next  = 1'b0;
          axis_next  = '0;
          state_next = action ? dsf3_pkg::ST_SNAP : dsf3_pkg::ST_T_DIV;
        end
      end
      dsf3_pkg::ST_SNAP: begin
        cmd.op     = dsf3_pkg::OP_SNAP;
        state_next = dsf3_pkg::ST_OUT;
      end
      dsf3_pkg::ST_T_DIV: begin
        cmd.op     = dsf3_pkg::OP_T_DIV;
        state_next = dsf3_pkg::ST_T_WAIT;
      end
      dsf3_pkg::ST_T_WAIT: begin
        if (status.div_done) state_next = dsf3_pkg::ST_T_SAVE;
      end
      dsf3_pkg::ST_T_SAVE: begin
        cmd.op     = dsf3_pkg::OP_T_SAVE;
        state_next = dsf3_pkg::ST_SK_MUL;
      end
      dsf3_pkg::ST_SK_MUL: begin
        cmd.op     = dsf3_pkg::OP_SK_MUL;
        state_next = dsf3_pkg::ST_SK_SAVE;
      end
      dsf3_pkg::ST_SK_SAVE: begin
        cmd.op     = dsf3_pkg::OP_SK_SAVE;
        state_next = dsf3_pkg::ST_V1;
      end
      dsf3_pkg::ST_V1: begin
        cmd.op     = dsf3_pkg::OP_V1;
        state_next = dsf3_pkg::ST_V2;
      end
      dsf3_pkg::ST_V2: begin
        cmd.op     = dsf3_pkg::OP_V2;
        state_next = dsf3_pkg::ST_V3;
      end
      dsf3_pkg::ST_V3: begin
        cmd.op     = dsf3_pkg::OP_V3;
        state_next = dsf3_pkg::ST_V4;
      end
      dsf3_pkg::ST_V4: begin
        cmd.op     = dsf3_pkg::OP_V4;
        state_next = dsf3_pkg::ST_V5;
      end
      dsf3_pkg::ST_V5: begin
        cmd.op = dsf3_pkg::OP_V5;
        if (last_axis) begin
          axis_next  = '0;
          state_next = dsf3_pkg::ST_L_MUL;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = dsf3_pkg::ST_V1;
        end
      end
      dsf3_pkg::ST_L_MUL: begin
        cmd.op     = dsf3_pkg::OP_L_MUL;
        state_next = dsf3_pkg::ST_L_ACC;
      end
      dsf3_pkg::ST_L_ACC: begin
        cmd.op = dsf3_pkg::OP_L_ACC;
        if (last_axis) begin
          axis_next  = '0;
          state_next = dsf3_pkg::ST_LIM_MUL;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = dsf3_pkg::ST_L_MUL;
        end
      end
      dsf3_pkg::ST_LIM_MUL: begin
        cmd.op     = dsf3_pkg::OP_LIM_MUL;
        state_next = dsf3_pkg::ST_LIM_CMP;
      end
      dsf3_pkg::ST_LIM_CMP: begin
        cmd.op     = dsf3_pkg::OP_LIM_CMP;
        state_next = status.over ? dsf3_pkg::ST_SQRT : dsf3_pkg::ST_P_MUL;
      end
      dsf3_pkg::ST_SQRT: begin
        cmd.op     = dsf3_pkg::OP_SQRT;
        state_next = dsf3_pkg::ST_SQRT_WAIT;
      end
      dsf3_pkg::ST_SQRT_WAIT: begin
        if (status.sqrt_done) state_next = dsf3_pkg::ST_LEN_SAVE;
      end
      dsf3_pkg::ST_LEN_SAVE: begin
        cmd.op     = dsf3_pkg::OP_LEN_SAVE;
        state_next = dsf3_pkg::ST_C_MUL;
      end
      dsf3_pkg::ST_C_MUL: begin
        cmd.op     = dsf3_pkg::OP_C_MUL;
        state_next = dsf3_pkg::ST_C_DIV;
      end
      dsf3_pkg::ST_C_DIV: begin
        cmd.op     = dsf3_pkg::OP_C_DIV;
        state_next = dsf3_pkg::ST_C_WAIT;
      end
      dsf3_pkg::ST_C_WAIT: begin
        if (status.div_done) state_next = dsf3_pkg::ST_C_WR;
      end
      dsf3_pkg::ST_C_WR: begin
        cmd.op = dsf3_pkg::OP_C_WR;
        if (last_axis) begin
          axis_next  = '0;
          state_next = dsf3_pkg::ST_P_MUL;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = dsf3_pkg::ST_C_MUL;
        end
      end
      dsf3_pkg::ST_P_MUL: begin
        cmd.op     = dsf3_pkg::OP_P_MUL;
        state_next = dsf3_pkg::ST_P_ADD;
      end
      dsf3_pkg::ST_P_ADD: begin
        cmd.op = dsf3_pkg::OP_P_ADD;
        if (last_axis) begin
          axis_next = '0;
          if (foll) begin
            state_next = dsf3_pkg::ST_OUT;
          end else begin
            foll_next  = 1'b1;
            state_next = dsf3_pkg::ST_V1;
          end
        end else begin
          axis_next  = axis + 2'd1;
          state_next = dsf3_pkg::ST_P_MUL;
        end
      end
      dsf3_pkg::ST_OUT: begin
        if (!status.out_busy) begin
          cmd.op     = dsf3_pkg::OP_OUT;
          state_next = dsf3_pkg::ST_IDLE;
        end
      end
      default: state_next = dsf3_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/damped_spring_follower_3d_unit.sv -----
// ----------------------------------------------------------------------------
// damped_spring_follower_3d_unit
// Two 3D spring-damper followers (look point and eye point), Q16.16.
//
// Input channel (in_valid/in_ready) takes one word per frame: an action,
// six goal coordinates and the frame time. Output channel
// (out_valid/out_ready) returns one word per input word: the new points
// and the two speed-limit flags.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data);
// write it only while the unit is idle.
// One word at a time is in work; in_ready is high only between words.
// The spring gain divide is the longest part of a step; each follower
// whose speed is limited adds a square root and three divides, one per
// axis. A snap goes straight from capture to the output register.
// The result sits in an output register, so a stalled receiver does not
// hold up the next word's work, only its hand-off.
// Reset (rst, synchronous) zeroes both points and velocities, loads the
// default registers and empties the output register.
// ----------------------------------------------------------------------------
module damped_spring_follower_3d_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic signed [31:0] goal_look_x,
  input  logic signed [31:0] goal_look_y,
  input  logic signed [31:0] goal_look_z,
  input  logic signed [31:0] goal_eye_x,
  input  logic signed [31:0] goal_eye_y,
  input  logic signed [31:0] goal_eye_z,
  input  logic [15:0]        frame_dt,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] look_x,
  output logic signed [31:0] look_y,
  output logic signed [31:0] look_z,
  output logic signed [31:0] eye_x,
  output logic signed [31:0] eye_y,
  output logic signed [31:0] eye_z,
  output logic               look_clamped,
  output logic               eye_clamped
);

  dsf3_pkg::cmd_t    cmd;
  dsf3_pkg::status_t status;

  dsf3_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .status   (status),
    .cmd      (cmd)
  );

  dsf3_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .goal_look_x  (goal_look_x),
    .goal_look_y  (goal_look_y),
    .goal_look_z  (goal_look_z),
    .goal_eye_x   (goal_eye_x),
    .goal_eye_y   (goal_eye_y),
    .goal_eye_z   (goal_eye_z),
    .frame_dt     (frame_dt),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .look_x       (look_x),
    .look_y       (look_y),
    .look_z       (look_z),
    .eye_x        (eye_x),
    .eye_y        (eye_y),
    .eye_z        (eye_z),
    .look_clamped (look_clamped),
    .eye_clamped  (eye_clamped)
  );

endmodule

// ----- hw/rtl/dsf3_checker.sv -----
// ----------------------------------------------------------------------------
// dsf3_checker
// Port-level checks on the follower unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dsf3_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] look_x,
  input logic [31:0] eye_x
);

  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid)
  `ASSERT_CLK(a_out_stable, clk, rst, out_valid && !out_ready |=> $stable(look_x) && $stable(eye_x))
  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)
  `ASSERT_CLK(a_busy_after_accept, clk, rst, in_valid && in_ready |=> !in_ready)

endmodule

bind damped_spring_follower_3d_unit dsf3_checker u_dsf3_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .look_x    (look_x),
  .eye_x     (eye_x)
);
